// ===== design/cfvg_pkg.sv =====
// shared constants, types and a function for the circle fan vertex generator
// no dependencies
`timescale 1ns / 1ps

package cfvg_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int MAX_SIDES    = 4096;
    localparam int TABLE_LEN    = 24;
    localparam int NSTEPS       = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

    localparam int IDX_W   = 13;
    localparam int XY_W    = 20;
    localparam int RAD_W   = 16;
    localparam int SIDES_W = 13;
    localparam int NUM_W   = IDX_W + 16;
    localparam int PH_W    = 16;
    localparam int CW      = 34;
    localparam int ZW      = 34;
    localparam int DIV_STEPS = NUM_W;

    localparam logic [2:0] REG_CENTER_X  = 3'd0;
    localparam logic [2:0] REG_CENTER_Y  = 3'd1;
    localparam logic [2:0] REG_CENTER_Z  = 3'd2;
    localparam logic [2:0] REG_RADIUS    = 3'd3;
    localparam logic [2:0] REG_NUM_SIDES = 3'd4;

    localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;

    typedef struct packed {
        logic             valid;
        logic             use_center;
        logic             is_last;
        logic             index_error;
    } tag_t;

    typedef struct packed {
        tag_t                     tag;
        logic [NUM_W-1:0]         rem;
        logic [NUM_W-1:0]         num;
        logic [PH_W-1:0]          quo;
        logic [SIDES_W-1:0]       sides;
    } div_word_t;

    typedef struct packed {
        tag_t                     tag;
        logic                     flip;
        logic signed [CW-1:0]     x;
        logic signed [CW-1:0]     y;
        logic signed [ZW-1:0]     z;
    } cor_word_t;

    function automatic logic signed [ZW-1:0] atan_turn(input int k);
        logic signed [ZW-1:0] t;
        begin
            case (k)
                0: t = 34'sd536870912;
                1: t = 34'sd316933406;
                2: t = 34'sd167458907;
                3: t = 34'sd85004756;
                4: t = 34'sd42667331;
                5: t = 34'sd21354465;
                6: t = 34'sd10679838;
                7: t = 34'sd5340245;
                8: t = 34'sd2670163;
                9: t = 34'sd1335087;
                10: t = 34'sd667544;
                11: t = 34'sd333772;
                12: t = 34'sd166886;
                13: t = 34'sd83443;
                14: t = 34'sd41722;
                15: t = 34'sd20861;
                16: t = 34'sd10430;
                17: t = 34'sd5215;
                18: t = 34'sd2608;
                19: t = 34'sd1304;
                20: t = 34'sd652;
                21: t = 34'sd326;
                22: t = 34'sd163;
                23: t = 34'sd81;
                default: t = '0;
            endcase
            return t;
        end
    endfunction

endpackage

// ===== design/cfvg_div_cell.sv =====
// one restoring division cell: brings in one numerator bit per cycle
// depends on cfvg_pkg
`timescale 1ns / 1ps

module cfvg_div_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  cfvg_pkg::div_word_t din,
    output cfvg_pkg::div_word_t dout
);

    cfvg_pkg::div_word_t word_reg;
    cfvg_pkg::div_word_t word_next;
    logic [cfvg_pkg::NUM_W:0] trial;

    always_comb
    begin
        word_next = din;
        trial = {din.rem, din.num[cfvg_pkg::NUM_W-1]}
              - {{(cfvg_pkg::NUM_W-cfvg_pkg::SIDES_W+1){1'b0}}, din.sides};
        word_next.num = {din.num[cfvg_pkg::NUM_W-2:0], 1'b0};
        if (!trial[cfvg_pkg::NUM_W])
        begin
            word_next.rem = trial[cfvg_pkg::NUM_W-1:0];
            word_next.quo = {din.quo[cfvg_pkg::PH_W-2:0], 1'b1};
        end
        else
        begin
            word_next.rem = {din.rem[cfvg_pkg::NUM_W-2:0], din.num[cfvg_pkg::NUM_W-1]};
            word_next.quo = {din.quo[cfvg_pkg::PH_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else
        begin
            word_reg <= word_next;
        end
    end

    assign dout = word_reg;

endmodule

// ===== design/cfvg_cordic_cell.sv =====
// one cordic rotation cell with a fixed shift, registered output
// depends on cfvg_pkg
`timescale 1ns / 1ps

module cfvg_cordic_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [4:0]          step,
    input  cfvg_pkg::cor_word_t din,
    output cfvg_pkg::cor_word_t dout
);

    cfvg_pkg::cor_word_t word_reg;
    cfvg_pkg::cor_word_t word_next;
    logic signed [cfvg_pkg::CW-1:0] xs;
    logic signed [cfvg_pkg::CW-1:0] ys;

    always_comb
    begin
        word_next = din;
        xs = din.x >>> step;
        ys = din.y >>> step;
        if (!din.z[cfvg_pkg::ZW-1])
        begin
            word_next.x = din.x - ys;
            word_next.y = din.y + xs;
            word_next.z = din.z - cfvg_pkg::atan_turn(int'(step));
        end
        else
        begin
            word_next.x = din.x + ys;
            word_next.y = din.y - xs;
            word_next.z = din.z + cfvg_pkg::atan_turn(int'(step));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else
        begin
            word_reg <= word_next;
        end
    end

    assign dout = word_reg;

endmodule

// ===== design/circle_fan_vertex_generator.sv =====
// top level: config registers, divider cell chain, cordic cell chain, output stage
// depends on cfvg_pkg, cfvg_div_cell, cfvg_cordic_cell
`timescale 1ns / 1ps

// circle triangle-fan vertex generator
// config: write cfg_index/cfg_data with cfg_valid; cfg_ready is always high.
// registers: 0 center_x, 1 center_y, 2 center_z, 3 radius, 4 num_sides.
// write config only while no vertex is in flight.
// input: pulse start with vertex_index; busy is never high, so one index
// may be issued every clock.
// output: done strobes for one cycle with vert_x/y/z, is_last, index_error.
// pipeline: 29 divider cells (one numerator bit per cell), 16 cordic cells,
// then a trig rounding stage, a radius product stage and an output register
// that adds the center and saturates, in that order from start to done.
// throughput: one vertex per clock, set by the cell chains.
// reset: config returns to defaults (num_sides 100, rest 0) and the
// pipeline empties; no done strobe until a new start.
// the receiver cannot stall; each result is shown for exactly one cycle.

module circle_fan_vertex_generator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [2:0]                          cfg_index,
    input  logic [31:0]                         cfg_data,
    input  logic                                start,
    output logic                                busy,
    input  logic [cfvg_pkg::IDX_W-1:0]          vertex_index,
    output logic                                done,
    output logic signed [cfvg_pkg::XY_W-1:0]    vert_x,
    output logic signed [cfvg_pkg::XY_W-1:0]    vert_y,
    output logic signed [cfvg_pkg::XY_W-1:0]    vert_z,
    output logic                                is_last,
    output logic                                index_error
);

    localparam int XY_W = cfvg_pkg::XY_W;

    logic signed [XY_W-1:0]              center_x_reg;
    logic signed [XY_W-1:0]              center_y_reg;
    logic signed [XY_W-1:0]              center_z_reg;
    logic [cfvg_pkg::RAD_W-1:0]          radius_reg;
    logic [cfvg_pkg::SIDES_W-1:0]        num_sides_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg  <= '0;
            center_y_reg  <= '0;
            center_z_reg  <= '0;
            radius_reg    <= '0;
            num_sides_reg <= cfvg_pkg::SIDES_W'(100);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                cfvg_pkg::REG_CENTER_X:  center_x_reg  <= cfg_data[XY_W-1:0];
                cfvg_pkg::REG_CENTER_Y:  center_y_reg  <= cfg_data[XY_W-1:0];
                cfvg_pkg::REG_CENTER_Z:  center_z_reg  <= cfg_data[XY_W-1:0];
                cfvg_pkg::REG_RADIUS:    radius_reg    <= cfg_data[cfvg_pkg::RAD_W-1:0];
                cfvg_pkg::REG_NUM_SIDES: num_sides_reg <= cfg_data[cfvg_pkg::SIDES_W-1:0];
                default: ;
            endcase
        end
    end

    // effective sides and index classification
    logic [cfvg_pkg::SIDES_W-1:0] sides;
    logic [cfvg_pkg::SIDES_W:0]   sides_p1;
    cfvg_pkg::div_word_t          div_in;
    logic                         accept;

    assign accept = start && !busy;

    always_comb
    begin
        if (num_sides_reg == '0)
            sides = cfvg_pkg::SIDES_W'(1);
        else if (num_sides_reg > cfvg_pkg::SIDES_W'(cfvg_pkg::MAX_SIDES))
            sides = cfvg_pkg::SIDES_W'(cfvg_pkg::MAX_SIDES);
        else
            sides = num_sides_reg;
        sides_p1 = {1'b0, sides} + 1'b1;
        div_in.tag.valid       = accept;
        div_in.tag.index_error = {1'b0, vertex_index} > sides_p1;
        div_in.tag.is_last     = {1'b0, vertex_index} == sides_p1;
        div_in.tag.use_center  = (vertex_index == '0) || div_in.tag.index_error;
        div_in.rem   = '0;
        div_in.num   = {vertex_index, 16'h0000};
        div_in.quo   = '0;
        div_in.sides = sides;
    end

    cfvg_pkg::div_word_t div_chain [cfvg_pkg::DIV_STEPS+1];
    assign div_chain[0] = div_in;

    genvar gi;
    generate
        for (gi = 0; gi < cfvg_pkg::DIV_STEPS; gi++)
        begin : g_div
            cfvg_div_cell u_cell (
                .clk  (clk),
                .rst_n(rst_n),
                .din  (div_chain[gi]),
                .dout (div_chain[gi+1])
            );
        end
    endgenerate

    // quadrant fold into cordic range
    cfvg_pkg::cor_word_t cor_chain [cfvg_pkg::NSTEPS+1];
    logic [31:0] ang;
    logic [31:0] ang_f;
    logic        flip;

    always_comb
    begin
        ang  = {div_chain[cfvg_pkg::DIV_STEPS].quo, 16'h0000};
        flip = ang[31] ^ ang[30];
        ang_f = flip ? (ang - 32'h8000_0000) : ang;
        cor_chain[0].tag  = div_chain[cfvg_pkg::DIV_STEPS].tag;
        cor_chain[0].flip = flip;
        cor_chain[0].x    = cfvg_pkg::GAIN_Q30;
        cor_chain[0].y    = '0;
        cor_chain[0].z    = {{(cfvg_pkg::ZW-32){ang_f[31]}}, ang_f};
    end

    generate
        for (gi = 0; gi < cfvg_pkg::NSTEPS; gi++)
        begin : g_cor
            cfvg_cordic_cell u_cell (
                .clk  (clk),
                .rst_n(rst_n),
                .step (5'(gi)),
                .din  (cor_chain[gi]),
                .dout (cor_chain[gi+1])
            );
        end
    endgenerate

    // round trig to q1.15
    cfvg_pkg::cor_word_t cend;
    logic signed [cfvg_pkg::CW:0] cx;
    logic signed [cfvg_pkg::CW:0] cy;
    logic signed [cfvg_pkg::CW:0] rx;
    logic signed [cfvg_pkg::CW:0] ry;
    logic signed [16:0] cos_next;
    logic signed [16:0] sin_next;

    function automatic logic signed [16:0] sat16(input logic signed [cfvg_pkg::CW:0] v);
        logic signed [cfvg_pkg::CW:0] lo;
        logic signed [cfvg_pkg::CW:0] hi;
        begin
            lo = -(cfvg_pkg::CW+1)'(32768);
            hi = (cfvg_pkg::CW+1)'(32767);
            if (v < lo)
                return -17'sd32768;
            else if (v > hi)
                return 17'sd32767;
            else
                return v[16:0];
        end
    endfunction

    always_comb
    begin
        cend = cor_chain[cfvg_pkg::NSTEPS];
        cx = cend.flip ? -(cfvg_pkg::CW+1)'(cend.x) : (cfvg_pkg::CW+1)'(cend.x);
        cy = cend.flip ? -(cfvg_pkg::CW+1)'(cend.y) : (cfvg_pkg::CW+1)'(cend.y);
        rx = (cx + (cfvg_pkg::CW+1)'(16384)) >>> 15;
        ry = (cy + (cfvg_pkg::CW+1)'(16384)) >>> 15;
        cos_next = sat16(rx);
        sin_next = sat16(ry);
    end

    // stage a: trig registered
    cfvg_pkg::tag_t     tag_a_reg;
    logic signed [16:0] cos_a_reg;
    logic signed [16:0] sin_a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tag_a_reg <= '0;
        else
            tag_a_reg <= cend.tag;
    end

    always_ff @(posedge clk)
    begin
        cos_a_reg <= cos_next;
        sin_a_reg <= sin_next;
    end

    // stage b: radius products
    cfvg_pkg::tag_t     tag_b_reg;
    logic signed [33:0] px_reg;
    logic signed [33:0] py_reg;
    logic signed [16:0] rad_s;

    assign rad_s = {1'b0, radius_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tag_b_reg <= '0;
        else
            tag_b_reg <= tag_a_reg;
    end

    always_ff @(posedge clk)
    begin
        px_reg <= rad_s * cos_a_reg;
        py_reg <= rad_s * sin_a_reg;
    end

    // stage c: round, add center, saturate
    logic signed [XY_W+1:0] sx;
    logic signed [XY_W+1:0] sy;
    logic signed [33:0]     ox;
    logic signed [33:0]     oy;

    function automatic logic signed [XY_W-1:0] sat20(input logic signed [XY_W+1:0] v);
        begin
            if (v < -(XY_W+2)'(524288))
                return -20'sd524288;
            else if (v > (XY_W+2)'(524287))
                return 20'sd524287;
            else
                return v[XY_W-1:0];
        end
    endfunction

    always_comb
    begin
        ox = (px_reg + 34'sd16384) >>> 15;
        oy = (py_reg + 34'sd16384) >>> 15;
        sx = (XY_W+2)'(center_x_reg) + ox[XY_W+1:0];
        sy = (XY_W+2)'(center_y_reg) + oy[XY_W+1:0];
    end

    logic                   done_reg;
    logic signed [XY_W-1:0] vx_reg;
    logic signed [XY_W-1:0] vy_reg;
    logic                   last_reg;
    logic                   err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= tag_b_reg.valid;
    end

    always_ff @(posedge clk)
    begin
        vx_reg   <= tag_b_reg.use_center ? center_x_reg : sat20(sx);
        vy_reg   <= tag_b_reg.use_center ? center_y_reg : sat20(sy);
        last_reg <= tag_b_reg.is_last;
        err_reg  <= tag_b_reg.index_error;
    end

    assign done        = done_reg;
    assign vert_x      = vx_reg;
    assign vert_y      = vy_reg;
    assign vert_z      = center_z_reg;
    assign is_last     = last_reg;
    assign index_error = err_reg;

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(is_last && index_error))
        else $error("is_last and index_error both set");

    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    a_done_follows_tag: assert property (@(posedge clk) disable iff (!rst_n)
        tag_b_reg.valid |=> done)
        else $error("result lost in output stage");

endmodule
